### sv/tsgm_pkg.sv
`timescale 1ns / 1ps

package tsgm_pkg;

	// input item kinds (carried on s_tuser)
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_SEED = 2'd1;
	localparam logic [1:0] ACT_DRAW = 2'd2;

	// mutation step directions
	localparam logic [1:0] DIR_X_UP   = 2'd0;
	localparam logic [1:0] DIR_X_DOWN = 2'd1;
	localparam logic [1:0] DIR_Y_UP   = 2'd2;
	localparam logic [1:0] DIR_Y_DOWN = 2'd3;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_POP_SIZE    = 2'd2;

	// stream payload widths
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 72;

	localparam int FIT_W  = 16;
	localparam int GENE_W = 6;

	// population entry: {fit[27:12], y[11:6], x[5:0]}
	typedef struct packed {
		logic [FIT_W-1:0]  fit;
		logic [GENE_W-1:0] y;
		logic [GENE_W-1:0] x;
	} pop_entry_t;

	localparam int POP_ENTRY_W = $bits(pop_entry_t);

	// effective (clamped) configuration
	typedef struct packed {
		logic [6:0] width;
		logic [6:0] height;
		logic [8:0] pop;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_DRAW,
		ST_CHILD
	} eng_state_t;

endpackage

### sv/tsgm_ram.sv
`timescale 1ns / 1ps

module tsgm_ram #(
	parameter int DW    = 16,
	parameter int AW    = 12,
	parameter int DEPTH = 4096
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/tsgm_engine.sv
`timescale 1ns / 1ps

module tsgm_engine #(
	parameter int MAP_SIDE = 64,
	parameter int POP_MAX  = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tsgm_pkg::cfg_t                       cfg,
	// cell_x[5:0] cell_y[11:6] cell_value[27:12] entrant_index[35:28]
	// first_draw[36] mutate[37] direction[39:38]
	input  logic [tsgm_pkg::IN_DATA_W-1:0]       s_tdata,
	// action[1:0]
	input  logic [tsgm_pkg::IN_USER_W-1:0]       s_tuser,
	input  logic                                 s_tlast,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// child_x[5:0] child_y[11:6] child_fitness[27:12] child_slot[35:28]
	// generation_number[67:36], zero fill [71:68]
	output logic [tsgm_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready
);

	import tsgm_pkg::*;

	localparam int MAW = $clog2(MAP_SIDE * MAP_SIDE);
	localparam int PW  = $clog2(POP_MAX);

	eng_state_t state_q, state_nx;

	// input fields
	logic [GENE_W-1:0] in_cx, in_cy;
	logic [FIT_W-1:0]  in_val;
	logic [7:0]        in_idx;
	logic              in_first, in_mut;
	logic [1:0]        in_dir;
	logic              accept;

	// item held during its work
	logic [PW-1:0] idx_q;
	logic          first_q, last_q, mut_q;
	logic [1:0]    dir_q;

	// tournament / generation state
	pop_entry_t    best_q;
	logic          bank_q;
	logic [7:0]    cnt_q;
	logic [31:0]   gen_q;

	// child genes between draw and lookup
	logic [GENE_W-1:0] cx_q, cy_q;
	logic              oob_q;

	// output register
	logic              m_valid_q;
	logic [GENE_W-1:0] out_x_q, out_y_q;
	logic [FIT_W-1:0]  out_fit_q;
	logic [7:0]        out_slot_q;
	logic              out_end_q;
	logic [31:0]       out_gen_q;

	// memory ports
	logic                   map_we, map_re;
	logic [MAW-1:0]         map_waddr, map_raddr;
	logic [FIT_W-1:0]       map_rdata;
	logic                   pop_we, pop_re;
	logic [PW:0]            pop_waddr, pop_raddr;
	pop_entry_t             pop_wdata;
	logic [POP_ENTRY_W-1:0] pop_rdata;

	// combinational helpers
	logic [8:0]        n_m1;
	logic [7:0]        idx_cl;
	logic [GENE_W-1:0] sx, sy;
	pop_entry_t        entry, best_nx;
	logic              take;
	logic [GENE_W-1:0] mx, my;
	logic [FIT_W-1:0]  child_fit;
	logic              out_free, gen_end, do_child;
	logic [MAW-1:0]    center_addr, child_addr;

	assign in_cx    = s_tdata[5:0];
	assign in_cy    = s_tdata[11:6];
	assign in_val   = s_tdata[27:12];
	assign in_idx   = s_tdata[35:28];
	assign in_first = s_tdata[36];
	assign in_mut   = s_tdata[37];
	assign in_dir   = s_tdata[39:38];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// entrant / slot index clamps to pop - 1
	assign n_m1   = cfg.pop - 9'd1;
	assign idx_cl = ({1'b0, in_idx} > n_m1) ? n_m1[7:0] : in_idx;

	// grid center
	assign sx = cfg.width[6:1];
	assign sy = cfg.height[6:1];

	// tournament compare: strictly greater replaces
	assign entry   = pop_entry_t'(pop_rdata);
	assign take    = first_q || (entry.fit > best_q.fit);
	assign best_nx = take ? entry : best_q;

	// clamped mutation step on the winner
	always_comb begin
		mx = best_nx.x;
		my = best_nx.y;
		if (mut_q) begin
			case (dir_q)
				DIR_X_UP: begin
					if (({1'b0, best_nx.x} + 7'd1) < cfg.width) mx = best_nx.x + 6'd1;
				end
				DIR_X_DOWN: begin
					if (best_nx.x != '0) mx = best_nx.x - 6'd1;
				end
				DIR_Y_UP: begin
					if (({1'b0, best_nx.y} + 7'd1) < cfg.height) my = best_nx.y + 6'd1;
				end
				default: begin
					if (best_nx.y != '0) my = best_nx.y - 6'd1;
				end
			endcase
		end
	end

	assign center_addr = MAW'(32'(sy) * MAP_SIDE + 32'(sx));
	assign child_addr  = MAW'(32'(my) * MAP_SIDE + 32'(mx));

	// map memory accesses
	assign map_we    = accept && (s_tuser == ACT_LOAD)
		&& (32'(in_cx) < MAP_SIDE) && (32'(in_cy) < MAP_SIDE);
	assign map_waddr = MAW'(32'(in_cy) * MAP_SIDE + 32'(in_cx));
	assign map_re    = (accept && (s_tuser == ACT_SEED)) || ((state_q == ST_DRAW) && last_q);
	assign map_raddr = (state_q == ST_DRAW) ? child_addr : center_addr;

	// child completion
	assign child_fit = oob_q ? '0 : map_rdata;
	assign out_free  = !m_valid_q || m_tready;
	assign do_child  = (state_q == ST_CHILD) && out_free;
	assign gen_end   = ({1'b0, cnt_q} + 9'd1) >= cfg.pop;

	// population memory accesses
	assign pop_re    = accept && (s_tuser == ACT_DRAW);
	assign pop_raddr = {bank_q, PW'(idx_cl)};

	always_comb begin
		pop_we    = 1'b0;
		pop_waddr = {bank_q, idx_q};
		pop_wdata = '{fit: map_rdata, y: sy, x: sx};
		if (state_q == ST_SEED) begin
			pop_we = 1'b1;
		end else if (do_child) begin
			pop_we    = (32'(cnt_q) < POP_MAX);
			pop_waddr = {~bank_q, PW'(cnt_q)};
			pop_wdata = '{fit: child_fit, y: cy_q, x: cx_q};
		end
	end

	tsgm_ram #(
		.DW    (FIT_W),
		.AW    (MAW),
		.DEPTH (MAP_SIDE * MAP_SIDE)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (in_val),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	tsgm_ram #(
		.DW    (POP_ENTRY_W),
		.AW    (PW + 1),
		.DEPTH (2 * POP_MAX)
	) u_pop (
		.clk   (clk),
		.we    (pop_we),
		.waddr (pop_waddr),
		.wdata (pop_wdata),
		.re    (pop_re),
		.raddr (pop_raddr),
		.rdata (pop_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == ACT_SEED) state_nx = ST_SEED;
					else if (s_tuser == ACT_DRAW) state_nx = ST_DRAW;
				end
			end
			ST_SEED:  state_nx = ST_IDLE;
			ST_DRAW:  state_nx = last_q ? ST_CHILD : ST_IDLE;
			ST_CHILD: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default:  state_nx = ST_IDLE;
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= PW'(idx_cl);
			first_q <= in_first;
			last_q  <= s_tlast;
			mut_q   <= in_mut;
			dir_q   <= in_dir;
		end
	end

	// child genes and map-range flag
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW) begin
			cx_q  <= mx;
			cy_q  <= my;
			oob_q <= (32'(mx) >= MAP_SIDE) || (32'(my) >= MAP_SIDE);
		end
	end

	// tournament and generation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			bank_q <= 1'b0;
			cnt_q  <= '0;
			gen_q  <= '0;
		end else begin
			if (state_q == ST_DRAW) begin
				best_q <= best_nx;
			end
			if (do_child) begin
				if (gen_end) begin
					cnt_q  <= '0;
					bank_q <= ~bank_q;
					gen_q  <= gen_q + 32'd1;
				end else begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (do_child) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (do_child) begin
			out_x_q    <= cx_q;
			out_y_q    <= cy_q;
			out_fit_q  <= child_fit;
			out_slot_q <= cnt_q;
			out_end_q  <= gen_end;
			out_gen_q  <= gen_end ? gen_q + 32'd1 : gen_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = out_end_q;
	assign m_tdata  = {4'd0, out_gen_q, out_slot_q, out_fit_q, out_y_q, out_x_q};

endmodule

### sv/tournament_select_grid_mutate_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// s_*       in   s_tvalid / s_tready     tdata 40b, tuser = action, tlast = last_draw
// m_*       out  m_tvalid / m_tready     tdata 72b, tlast = generation_end
// APB       in   psel/penable/pready     grid_width @0x0, grid_height @0x4, pop_size @0x8
//
// A map load is written on acceptance; seed and plain draw wait in SEED or DRAW
// for a registered memory read; the last draw then also waits in CHILD for a map read.
// A child waits in its final step while the output register is still full;
// a held result does not block the next item from being accepted.
// Reset clears control, counters and the held best; both memories are not cleared.

module tournament_select_grid_mutate_top #(
	parameter int MAP_SIDE = 64,
	parameter int POP_MAX  = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// cell_x[5:0] cell_y[11:6] cell_value[27:12] entrant_index[35:28]
	// first_draw[36] mutate[37] direction[39:38]
	input  logic [tsgm_pkg::IN_DATA_W-1:0]       s_tdata,
	// action[1:0]
	input  logic [tsgm_pkg::IN_USER_W-1:0]       s_tuser,
	input  logic                                 s_tlast,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// child_x[5:0] child_y[11:6] child_fitness[27:12] child_slot[35:28]
	// generation_number[67:36], zero fill [71:68]
	output logic [tsgm_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [3:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	import tsgm_pkg::*;

	localparam int LIM_TOP = (MAP_SIDE < 64) ? MAP_SIDE : 64;

	logic [6:0] width_q, height_q;
	logic [8:0] pop_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			pop_q    <= 9'd256;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GRID_WIDTH:  width_q  <= pwdata[6:0];
				REG_GRID_HEIGHT: height_q <= pwdata[6:0];
				REG_POP_SIZE:    pop_q    <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_GRID_WIDTH:  prdata = {25'd0, width_q};
			REG_GRID_HEIGHT: prdata = {25'd0, height_q};
			REG_POP_SIZE:    prdata = {23'd0, pop_q};
			default:         prdata = '0;
		endcase
	end

	// effective limits
	always_comb begin
		cfg.width  = (width_q == '0) ? 7'd1
			: (32'(width_q) > LIM_TOP) ? 7'(LIM_TOP) : width_q;
		cfg.height = (height_q == '0) ? 7'd1
			: (32'(height_q) > LIM_TOP) ? 7'(LIM_TOP) : height_q;
		cfg.pop    = (pop_q == '0) ? 9'd1
			: (32'(pop_q) > POP_MAX) ? 9'(POP_MAX) : pop_q;
	end

	tsgm_engine #(
		.MAP_SIDE (MAP_SIDE),
		.POP_MAX  (POP_MAX)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

endmodule
